>>> rtl/ptb_pkg.sv
// Shared constants and types for the periodic timer bank.
// No dependencies; imported by every module of the block.
package ptb_pkg;

    // Number of timers in the bank (1 to 8)
    localparam int TIMER_COUNT = 8;

    // Field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 32;
    localparam int MASK_W  = 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;     // a beat is accepted this cycle
        logic tick;     // advance the tick total and all active timers
        logic start;    // load counter and reload of the indexed timer
        logic stop;     // clear counter and reload of the indexed timer
        logic reject;   // start or stop named a timer that does not exist
    } ptb_cmd_t;

endpackage

>>> rtl/ptb_ctrl.sv
// Controller of the periodic timer bank: handshake state and opcode decode.
// Depends on ptb_pkg.
module ptb_ctrl
    import ptb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [INDEX_W-1:0] timer_index,
    output logic               out_valid,
    input  logic               out_ready,
    output ptb_cmd_t           cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;
    logic index_bad;

    // Take a beat whenever the result register is free or being drained
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign accept    = in_valid && in_ready;

    // Decode the accepted beat
    assign index_bad = (timer_index >= INDEX_W'(TIMER_COUNT));

    always_comb
    begin
        cmd        = '0;
        cmd.exec   = accept;
        case (opcode)
            OP_TICK:
            begin
                cmd.tick = accept;
            end
            OP_START:
            begin
                cmd.start  = accept && !index_bad;
                cmd.reject = index_bad;
            end
            OP_STOP:
            begin
                cmd.stop   = accept && !index_bad;
                cmd.reject = index_bad;
            end
            default:
            begin
                cmd.reject = 1'b0;
            end
        endcase
    end

    // Track whether the result register holds an undelivered beat
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
                else if (out_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/ptb_datapath.sv
// Datapath of the periodic timer bank: timer counters, reloads, tick total
// and the result register. Depends on ptb_pkg.
module ptb_datapath
    import ptb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptb_cmd_t           cmd,
    input  logic [INDEX_W-1:0] timer_index,
    input  logic [VALUE_W-1:0] period_ticks,
    output logic [MASK_W-1:0]  expired_mask,
    output logic [VALUE_W-1:0] tick_count,
    output logic               rejected
);

    logic [VALUE_W-1:0] countdown_reg [TIMER_COUNT];
    logic [VALUE_W-1:0] countdown_next [TIMER_COUNT];
    logic [VALUE_W-1:0] reload_reg [TIMER_COUNT];
    logic [VALUE_W-1:0] reload_next [TIMER_COUNT];
    logic [VALUE_W-1:0] tick_total_reg;
    logic [VALUE_W-1:0] tick_total_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic               rejected_reg;

    // Advance every active timer on a tick, or load/clear the named one
    always_comb
    begin
        logic [VALUE_W-1:0] dec;
        mask_next = '0;
        dec       = '0;
        for (int t = 0; t < TIMER_COUNT; t++)
        begin
            countdown_next[t] = countdown_reg[t];
            reload_next[t]    = reload_reg[t];
            dec               = countdown_reg[t] - VALUE_W'(1);
            if (cmd.tick && (reload_reg[t] != '0))
            begin
                if (dec == '0)
                begin
                    countdown_next[t] = reload_reg[t];
                    mask_next         = mask_next | (MASK_W'(1) << t);
                end
                else
                begin
                    countdown_next[t] = dec;
                end
            end
            if (timer_index == INDEX_W'(t))
            begin
                if (cmd.start)
                begin
                    countdown_next[t] = period_ticks;
                    reload_next[t]    = period_ticks;
                end
                else if (cmd.stop)
                begin
                    countdown_next[t] = '0;
                    reload_next[t]    = '0;
                end
            end
        end
    end

    assign tick_total_next = tick_total_reg + VALUE_W'(1);

    // Hold timer state and the tick total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                countdown_reg[t] <= '0;
                reload_reg[t]    <= '0;
            end
            tick_total_reg <= '0;
        end
        else
        begin
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                countdown_reg[t] <= countdown_next[t];
                reload_reg[t]    <= reload_next[t];
            end
            if (cmd.tick)
            begin
                tick_total_reg <= tick_total_next;
            end
        end
    end

    // Capture the result of each accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            mask_reg     <= mask_next;
            rejected_reg <= cmd.reject;
        end
    end

    // The tick total changes only on an accepted beat, so it is the result field
    assign expired_mask = mask_reg;
    assign tick_count   = tick_total_reg;
    assign rejected     = rejected_reg;

endmodule

>>> rtl/periodic_timer_bank_unit.sv
// Periodic timer bank, top level.
// The input channel carries one command per beat: opcode (tick, start, stop),
// timer_index and period_ticks, under in_valid / in_ready.
// The output channel returns one result per command: expired_mask,
// tick_count and rejected, under out_valid / out_ready.
// A tick bumps the tick total and decrements every timer with a nonzero
// reload; a timer reaching zero reloads and sets its mask bit. A start loads
// counter and reload of one timer, a stop clears both; an index beyond the
// bank is ignored and flagged as rejected.
// The result is valid in the cycle after the command is accepted. Throughput
// is one command per cycle while out_ready is high: all timers are registers
// updated in parallel, and the single result register is refilled in the
// cycle it is drained. While the receiver stalls, the result holds and
// in_ready drops once the result register is full.
// Reset clears all counters, reloads and the tick total, leaving every timer
// inactive, and empties the result register.
module periodic_timer_bank_unit
    import ptb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [INDEX_W-1:0] timer_index,
    input  logic [VALUE_W-1:0] period_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MASK_W-1:0]  expired_mask,
    output logic [VALUE_W-1:0] tick_count,
    output logic               rejected
);

    ptb_cmd_t cmd;

    ptb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .timer_index (timer_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    ptb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .timer_index  (timer_index),
        .period_ticks (period_ticks),
        .expired_mask (expired_mask),
        .tick_count   (tick_count),
        .rejected     (rejected)
    );

`ifndef ASSERT_OFF
    // An accepted tick advances the reported total by one
    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_TICK))
        |=> (tick_count == $past(tick_count) + VALUE_W'(1)))
        else $error("tick did not advance tick_count");

    // Any other accepted beat leaves the total alone
    a_cmd_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode != OP_TICK)) |=> $stable(tick_count))
        else $error("non-tick beat changed tick_count");

    // A rejected command never reports expiries
    a_reject_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (expired_mask == '0))
        else $error("rejected result carries an expiry mask");

    // An empty result register always takes a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule
